// ----- hw/rtl/lcsr_pkg.sv -----
// Shared widths, reset values, request and register codes for the load-cell serial reader.
// Used by lcsr_ctrl, lcsr_datapath and the top level; depends on nothing.
package lcsr_pkg;

    localparam int RAW_W           = 24;
    localparam int WEIGHT_W        = 28;
    localparam int TMO_W           = 16;
    localparam int CPG_W           = 24;
    localparam int SCALE_SHIFT     = 12;
    localparam int DIVD_W          = RAW_W + SCALE_SHIFT;
    localparam int DIV_CNT_W       = $clog2(DIVD_W + 1);
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int CFG_IDX_W       = 1;

    localparam logic [TMO_W-1:0]    TIMEOUT_RESET = 16'd20000;
    localparam logic [CPG_W-1:0]    CPG_RESET     = 24'd52992;
    localparam logic [RAW_W-1:0]    SIGN_FLIP     = 24'h800000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX    = 28'hFFFFFFF;
    localparam logic [TMO_W-1:0]    WAIT_MAX      = 16'hFFFF;

    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_MEASURE = 2'd1;
    localparam logic [1:0] REQ_TARE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPG     = 1'b1;

    typedef struct packed {
        logic step;
        logic div_run;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_stat;

endpackage

// ----- hw/rtl/lcsr_ctrl.sv -----
// Sequencer of the load-cell serial reader: input handshake, divider wait, output register.
// Depends on lcsr_pkg; drives the command struct into lcsr_datapath.
module lcsr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  lcsr_pkg::t_stat i_stat,
    output lcsr_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.step     = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_run  = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_PUSH) && (!r_out_valid || i_out_ready);
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.step) begin
                        r_state <= i_stat.need_div ? S_DIV : S_PUSH;
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/lcsr_datapath.sv -----
// Datapath of the load-cell serial reader: tick state, config registers, tare,
// serial restoring divider and output register. Depends on lcsr_pkg.
module lcsr_datapath #(
    parameter int SAMPLE_BITS = lcsr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lcsr_pkg::t_cmd                     i_cmd,
    output lcsr_pkg::t_stat                    o_stat,
    input  logic [1:0]                         i_req_type,
    input  logic                               i_dt_level,
    input  logic                               i_cfg_wr,
    input  logic [lcsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lcsr_pkg::CPG_W-1:0]         i_cfg_data,
    output logic                               o_sck_level,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_was_tare,
    output logic                               o_timed_out,
    output logic [lcsr_pkg::RAW_W-1:0]         o_raw_offset,
    output logic [lcsr_pkg::WEIGHT_W-1:0]      o_weight_q4
);

    localparam int PW = $clog2(SAMPLE_BITS + 1);
    localparam int RW = lcsr_pkg::RAW_W;
    localparam int DW = lcsr_pkg::DIVD_W;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_CLOCK
    } t_phase;

    t_phase                          r_phase;
    logic [lcsr_pkg::TMO_W-1:0]      r_wait_cnt;
    logic [PW-1:0]                   r_pulse_cnt;
    logic [RW-1:0]                   r_shift;
    logic [RW-1:0]                   r_tare;
    logic                            r_pend_tare;
    logic                            r_clk_hi;
    logic [lcsr_pkg::TMO_W-1:0]      r_timeout;
    logic [lcsr_pkg::CPG_W-1:0]      r_cpg;

    t_phase                          n_phase;
    logic [lcsr_pkg::TMO_W-1:0]      n_wait_cnt;
    logic [PW-1:0]                   n_pulse_cnt;
    logic [RW-1:0]                   n_shift;
    logic [RW-1:0]                   n_tare;
    logic                            n_pend_tare;
    logic                            n_clk_hi;

    logic                            s_start;
    t_phase                          s_phase;
    logic                            s_tare_req;
    logic [lcsr_pkg::TMO_W-1:0]      s_wait;
    logic [lcsr_pkg::TMO_W-1:0]      s_wait_inc;
    logic                            s_sck;
    logic                            s_fin;
    logic                            s_tmo;
    logic [RW-1:0]                   s_raw;
    logic                            s_need_div;
    logic [RW-1:0]                   s_diff;

    logic                            r_w_sck;
    logic                            r_w_busy;
    logic                            r_w_done;
    logic                            r_w_tare;
    logic                            r_w_tmo;
    logic [RW-1:0]                   r_w_raw;
    logic                            r_w_div;

    logic [lcsr_pkg::CPG_W-1:0]      r_rem;
    logic [DW-1:0]                   r_quo;
    logic [lcsr_pkg::DIV_CNT_W-1:0]  r_div_cnt;
    logic [lcsr_pkg::CPG_W:0]        d_trial;
    logic [lcsr_pkg::CPG_W:0]        d_sub;
    logic                            d_ge;
    logic [lcsr_pkg::WEIGHT_W-1:0]   d_weight;

    logic                            r_o_sck;
    logic                            r_o_busy;
    logic                            r_o_done;
    logic                            r_o_tare;
    logic                            r_o_tmo;
    logic [RW-1:0]                   r_o_raw;
    logic [lcsr_pkg::WEIGHT_W-1:0]   r_o_weight;

    always_comb begin
        s_start    = (r_phase == PH_IDLE) &&
                     ((i_req_type == lcsr_pkg::REQ_MEASURE) ||
                      (i_req_type == lcsr_pkg::REQ_TARE));
        s_phase    = s_start ? PH_WAIT : r_phase;
        s_tare_req = s_start ? (i_req_type == lcsr_pkg::REQ_TARE) : r_pend_tare;
        s_wait     = s_start ? '0 : r_wait_cnt;
        s_wait_inc = (s_wait < lcsr_pkg::WAIT_MAX) ? s_wait + 1'b1 : s_wait;

        n_phase     = s_phase;
        n_wait_cnt  = s_wait;
        n_pulse_cnt = r_pulse_cnt;
        n_shift     = r_shift;
        n_tare      = r_tare;
        n_pend_tare = s_tare_req;
        n_clk_hi    = r_clk_hi;
        s_sck       = 1'b0;
        s_fin       = 1'b0;
        s_tmo       = 1'b0;
        s_raw       = '0;

        case (s_phase)
            PH_WAIT: begin
                if (!i_dt_level) begin
                    n_phase     = PH_CLOCK;
                    n_pulse_cnt = '0;
                    n_clk_hi    = 1'b0;
                    n_shift     = '0;
                end else begin
                    n_wait_cnt = s_wait_inc;
                    if (s_wait_inc >= r_timeout) begin
                        s_fin = 1'b1;
                        s_tmo = 1'b1;
                    end
                end
            end
            PH_CLOCK: begin
                if (!r_clk_hi) begin
                    s_sck    = 1'b1;
                    n_clk_hi = 1'b1;
                    if (r_pulse_cnt < PW'(SAMPLE_BITS)) begin
                        n_shift = {r_shift[RW-2:0], i_dt_level};
                    end
                end else begin
                    n_clk_hi    = 1'b0;
                    n_pulse_cnt = r_pulse_cnt + 1'b1;
                    if (r_pulse_cnt >= PW'(SAMPLE_BITS)) begin
                        s_fin = 1'b1;
                        s_raw = r_shift ^ lcsr_pkg::SIGN_FLIP;
                    end
                end
            end
            default: begin
            end
        endcase

        if (s_fin) begin
            n_phase     = PH_IDLE;
            n_pend_tare = 1'b0;
            n_clk_hi    = 1'b0;
            if (s_tare_req) begin
                n_tare = s_raw;
            end
        end

        s_diff     = s_raw - r_tare;
        s_need_div = s_fin && !s_tare_req && (s_raw > r_tare);
    end

    always_comb begin
        d_trial  = {r_rem, r_quo[DW-1]};
        d_ge     = (d_trial >= {1'b0, r_cpg});
        d_sub    = d_trial - {1'b0, r_cpg};
        d_weight = (r_quo[DW-1:lcsr_pkg::WEIGHT_W] != '0) ? lcsr_pkg::WEIGHT_MAX
                                                          : r_quo[lcsr_pkg::WEIGHT_W-1:0];
    end

    assign o_stat.need_div = s_need_div;
    assign o_stat.div_done = (r_div_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_wait_cnt  <= '0;
            r_pulse_cnt <= '0;
            r_shift     <= '0;
            r_tare      <= '0;
            r_pend_tare <= 1'b0;
            r_clk_hi    <= 1'b0;
            r_timeout   <= lcsr_pkg::TIMEOUT_RESET;
            r_cpg       <= lcsr_pkg::CPG_RESET;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    lcsr_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[lcsr_pkg::TMO_W-1:0];
                    lcsr_pkg::CFG_CPG:     r_cpg     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.step) begin
                r_phase     <= n_phase;
                r_wait_cnt  <= n_wait_cnt;
                r_pulse_cnt <= n_pulse_cnt;
                r_shift     <= n_shift;
                r_tare      <= n_tare;
                r_pend_tare <= n_pend_tare;
                r_clk_hi    <= n_clk_hi;
                if (s_need_div) begin
                    r_div_cnt <= lcsr_pkg::DIV_CNT_W'(DW);
                end
            end else if (i_cmd.div_run && (r_div_cnt != '0)) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_w_sck  <= s_sck;
            r_w_busy <= (n_phase != PH_IDLE);
            r_w_done <= s_fin;
            r_w_tare <= s_fin && s_tare_req;
            r_w_tmo  <= s_tmo;
            r_w_raw  <= s_raw;
            r_w_div  <= s_need_div;
            r_rem    <= '0;
            r_quo    <= {s_diff, {lcsr_pkg::SCALE_SHIFT{1'b0}}};
        end else if (i_cmd.div_run && (r_div_cnt != '0)) begin
            r_rem <= d_ge ? d_sub[lcsr_pkg::CPG_W-1:0] : d_trial[lcsr_pkg::CPG_W-1:0];
            r_quo <= {r_quo[DW-2:0], d_ge};
        end
        if (i_cmd.out_load) begin
            r_o_sck    <= r_w_sck;
            r_o_busy   <= r_w_busy;
            r_o_done   <= r_w_done;
            r_o_tare   <= r_w_tare;
            r_o_tmo    <= r_w_tmo;
            r_o_raw    <= r_w_raw;
            r_o_weight <= r_w_div ? d_weight : '0;
        end
    end

    assign o_sck_level  = r_o_sck;
    assign o_busy_res   = r_o_busy;
    assign o_done_res   = r_o_done;
    assign o_was_tare   = r_o_tare;
    assign o_timed_out  = r_o_tmo;
    assign o_raw_offset = r_o_raw;
    assign o_weight_q4  = r_o_weight;

endmodule

// ----- hw/rtl/load_cell_adc_serial_reader_unit.sv -----
// Top level of the load-cell converter serial reader.
// Depends on lcsr_pkg, lcsr_ctrl and lcsr_datapath.
//
// Each input word is one microsecond tick: request code (plain, measure, tare) and
// the sampled data-line level. Each tick yields exactly one output word with the
// clock level to drive, busy, done and, on done, the offset-binary reading and
// the weight in sixteenths of a gram. A measure or tare waits for the data line
// to go low (or times out), then runs SAMPLE_BITS+1 clock pulses of two ticks each.
// A tick that needs no division goes straight from accept to the output load.
// The tick that finishes a measure with a reading above tare runs the serial
// restoring divider, one quotient bit per cycle over 36 bits.
// One tick is in work at a time; the next is accepted once the current word
// sits in the output register.
// Configuration: write channel, index 0 timeout in ticks, index 1 counts per gram
// (Q8); always ready, write only while no tick is in work.
// Reset (synchronous, active low): reader idle, tare zero, registers at defaults,
// no output word. A stalled receiver holds the output word; one further tick is
// processed and held until the output register frees.
module load_cell_adc_serial_reader_unit #(
    parameter int SAMPLE_BITS = lcsr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_req_type,
    input  logic                               i_dt_level,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_sck_level,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_was_tare,
    output logic                               o_timed_out,
    output logic [lcsr_pkg::RAW_W-1:0]         o_raw_offset,
    output logic [lcsr_pkg::WEIGHT_W-1:0]      o_weight_q4,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lcsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lcsr_pkg::CPG_W-1:0]         i_cfg_data
);

    lcsr_pkg::t_cmd  cmd;
    lcsr_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    lcsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lcsr_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_dt_level   (i_dt_level),
        .i_cfg_wr     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_sck_level  (o_sck_level),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_was_tare   (o_was_tare),
        .o_timed_out  (o_timed_out),
        .o_raw_offset (o_raw_offset),
        .o_weight_q4  (o_weight_q4)
    );

    a_tmo_raw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_timed_out) |-> (o_raw_offset == '0 && o_done_res))
        else $error("timed-out word carries a nonzero reading");

    a_tare_no_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_tare) |-> (o_weight_q4 == '0 && o_done_res))
        else $error("tare word carries a weight");

    a_idle_word_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |->
        (o_raw_offset == '0 && o_weight_q4 == '0 && !o_was_tare && !o_timed_out))
        else $error("result fields set without done");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("busy set on the finishing tick");

endmodule
